[rtl/core/sida_pkg.sv]
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the signed decimal text converter
// Holds the sequencer state type and the ASCII codes the converter emits.
// ----------------------------------------------------------------------------
package sida_pkg;

  // ASCII codes
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

endpackage

[rtl/core/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: two's-complement integer to decimal ASCII text
// Converts one signed value into its decimal characters, sign first, most
// significant digit first, with a last flag on the final character.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_value and raise start; the value is taken at a clock edge where
//   start is high and busy is low. busy then stays high until the final
//   character has been launched.
//   Characters appear on out_text_char with out_last, each for one cycle,
//   marked by out_valid. The receiver has no way to hold them off: every
//   out_valid cycle is one beat taken.
// Sequence (VALUE_WIDTH = W, digit slots ND = W*301/1000 + 1, text of D digits):
//   shift-and-add-3 binary to BCD conversion over all W bits on one shared
//   digit-adjust unit, then the ND - D leading zero digits are dropped,
//   then one character per cycle (sign, then D digits). The next value can
//   be taken in the cycle the final character is on the outputs.
//   At W = 32 there are ND = 10 digit slots.
// Reset: rst_n low at a clock edge returns the sequencer to idle and drops
//   out_valid; no character in flight is finished.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [7:0]                    out_text_char,
  output logic                          out_last
);

  localparam int ND    = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int BCD_W = ND * 4;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_CONV = CNT_W'(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_DIG  = CNT_W'(ND);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  sida_pkg::state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [3:0]             top_digit;
  logic [VALUE_WIDTH-1:0] mag_in;

  // Magnitude of the incoming value; the most negative value wraps to 2^(W-1)
  assign mag_in    = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // Shared digit-adjust unit: add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // Advance the sequencer and launch characters
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      sida_pkg::ST_IDLE: begin
        if (start) begin
          bin_nxt   = mag_in;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_CONV;
          neg_nxt   = in_value[VALUE_WIDTH-1];
          state_nxt = sida_pkg::ST_CONV;
        end
      end
      sida_pkg::ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_ONE) begin
          cnt_nxt   = CNT_DIG;
          state_nxt = sida_pkg::ST_SKIP;
        end
      end
      sida_pkg::ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (top_digit == 4'd0 && cnt_r != CNT_ONE) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sida_pkg::MINUS_CHAR;
        out_last_nxt  = 1'b0;
        state_nxt     = sida_pkg::ST_DIGITS;
      end
      sida_pkg::ST_DIGITS: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sida_pkg::DIGIT_BASE + {4'd0, top_digit};
        out_last_nxt  = (cnt_r == CNT_ONE);
        bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == CNT_ONE) begin
          state_nxt = sida_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sida_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sida_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != sida_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted value did not raise busy");

  a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sida_pkg::ST_IDLE) |=> !out_valid_r)
    else $error("character launched from idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("beat directly after final character");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == sida_pkg::MINUS_CHAR ||
                     (out_char_r >= sida_pkg::DIGIT_BASE &&
                      out_char_r <= sida_pkg::DIGIT_BASE + 8'd9)))
    else $error("character outside sign and digit codes");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sida_pkg::ST_CONV || state_r == sida_pkg::ST_DIGITS) |->
      (cnt_r != '0))
    else $error("step count ran out while working");

endmodule
